FILE: rtl/simd_sp_pkg.sv
// shared constants, opcodes and item type for the simd select and permute unit
package simd_sp_pkg;

   localparam int VEC_BYTES      = 8;
   localparam int TABLE_REGS_MAX = 4;
   localparam int BYTE_W         = 8;
   localparam int VEC_W          = VEC_BYTES * BYTE_W;
   localparam int TABLE_WORDS    = 2 * TABLE_REGS_MAX;
   localparam int WORD_AW        = $clog2(TABLE_WORDS);
   localparam int BYTE_SEL_W     = $clog2(VEC_BYTES);
   localparam int OP_W           = 4;
   localparam int ELEM_LOG2_W    = 2;
   localparam int EXT_W          = 4;
   localparam int REGS_W         = 3;
   localparam int TBL_WORD_W     = 3;

   localparam logic [ELEM_LOG2_W-1:0] ELEM_LOG2_FALLBACK = 2'd3;

   typedef enum logic [OP_W-1:0] {
      OP_BSL  = 4'd0,
      OP_BIT  = 4'd1,
      OP_BIF  = 4'd2,
      OP_TRN1 = 4'd3,
      OP_TRN2 = 4'd4,
      OP_ZIP1 = 4'd5,
      OP_ZIP2 = 4'd6,
      OP_UZP1 = 4'd7,
      OP_UZP2 = 4'd8,
      OP_EXT  = 4'd9,
      OP_TBL  = 4'd10,
      OP_TBX  = 4'd11,
      OP_LOAD = 4'd12
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0]        op;
      logic [ELEM_LOG2_W-1:0] elem_size_log2;
      logic [VEC_W-1:0]       dest_old;
      logic [VEC_W-1:0]       first_src;
      logic [VEC_W-1:0]       second_src;
      logic [EXT_W-1:0]       ext_index;
      logic [REGS_W-1:0]      table_regs;
   } item_type;

endpackage

FILE: rtl/simd_sp_table.sv
// lookup table store, one copy per result byte lane, with registered reads
module simd_sp_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_en,
   input  logic [simd_sp_pkg::WORD_AW-1:0]   wr_addr,
   input  logic [simd_sp_pkg::VEC_W-1:0]     wr_data,
   input  logic                              rd_en,
   input  logic [simd_sp_pkg::VEC_W-1:0]     rd_idx,
   output logic [simd_sp_pkg::VEC_W-1:0]     rd_bytes
);
   import simd_sp_pkg::*;

   logic [TABLE_WORDS-1:0] vld_ff;
   logic [TABLE_WORDS-1:0] vld_in;

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   for (genvar g = 0; g < VEC_BYTES; g++) begin : g_lane
      logic [VEC_W-1:0]      mem_ff [TABLE_WORDS];
      logic [VEC_W-1:0]      word_ff;
      logic                  word_vld_ff;
      logic [BYTE_SEL_W-1:0] sel_ff;
      logic [WORD_AW-1:0]    rd_addr;

      assign rd_addr = rd_idx[g*BYTE_W + BYTE_SEL_W +: WORD_AW];

      always_ff @(posedge clock) begin
         if (wr_en) begin
            mem_ff[wr_addr] <= wr_data;
         end
         if (rd_en) begin
            word_ff     <= mem_ff[rd_addr];
            word_vld_ff <= vld_ff[rd_addr];
            sel_ff      <= rd_idx[g*BYTE_W +: BYTE_SEL_W];
         end
      end

      // an entry never written reads as zero
      assign rd_bytes[g*BYTE_W +: BYTE_W] =
         word_vld_ff ? word_ff[BYTE_W*sel_ff +: BYTE_W] : '0;
   end

endmodule

FILE: rtl/simd_sp_alu.sv
// select, permute, extract and table lookup datapath for one item
module simd_sp_alu (
   input  simd_sp_pkg::item_type           item,
   input  logic [simd_sp_pkg::VEC_W-1:0]   tbl_bytes,
   output logic [simd_sp_pkg::VEC_W-1:0]   result,
   output logic                            fallback
);
   import simd_sp_pkg::*;

   logic [VEC_W-1:0]   perm_res;
   logic [VEC_W-1:0]   ext_res;
   logic [VEC_W-1:0]   tbl_res;
   logic [2*VEC_W-1:0] ext_pair;
   logic [REGS_W-1:0]  regs_sat;
   logic [6:0]         tbl_len;

   // lane permutes, one output byte at a time
   always_comb begin
      logic [3:0] elem;
      logic [3:0] elem_off;
      logic [3:0] lanes;
      logic [3:0] half;
      logic [3:0] src;
      logic [3:0] src_byte;
      logic       from_b;
      perm_res = '0;
      for (int j = 0; j < VEC_BYTES; j++) begin
         elem     = 4'(j) >> item.elem_size_log2;
         elem_off = 4'(j) & ((4'd1 << item.elem_size_log2) - 4'd1);
         lanes    = 4'(VEC_BYTES) >> item.elem_size_log2;
         half     = lanes >> 1;
         from_b   = elem[0];
         src      = elem;
         case (item.op)
            OP_TRN1: begin
               src = elem & ~4'd1;
            end
            OP_TRN2: begin
               src = (elem & ~4'd1) + 4'd1;
            end
            OP_ZIP1: begin
               src = elem >> 1;
            end
            OP_ZIP2: begin
               src = half + (elem >> 1);
            end
            OP_UZP1: begin
               from_b = (elem >= half);
               src    = (from_b ? elem - half : elem) << 1;
            end
            default: begin
               from_b = (elem >= half);
               src    = ((from_b ? elem - half : elem) << 1) + 4'd1;
            end
         endcase
         src      = src & (lanes - 4'd1);
         src_byte = (src << item.elem_size_log2) | elem_off;
         perm_res[j*BYTE_W +: BYTE_W] = from_b ?
            item.second_src[BYTE_W*src_byte[BYTE_SEL_W-1:0] +: BYTE_W] :
            item.first_src[BYTE_W*src_byte[BYTE_SEL_W-1:0] +: BYTE_W];
      end
   end

   assign ext_pair = {item.second_src, item.first_src} >>
                     (BYTE_W * item.ext_index[BYTE_SEL_W-1:0]);
   assign ext_res  = ext_pair[VEC_W-1:0];

   assign regs_sat = (item.table_regs > REGS_W'(TABLE_REGS_MAX)) ?
                     REGS_W'(TABLE_REGS_MAX) : item.table_regs;
   assign tbl_len  = {regs_sat, 4'b0000};

   always_comb begin
      logic [BYTE_W-1:0] k;
      tbl_res = '0;
      for (int i = 0; i < VEC_BYTES; i++) begin
         k = item.first_src[i*BYTE_W +: BYTE_W];
         if (k < {1'b0, tbl_len}) begin
            tbl_res[i*BYTE_W +: BYTE_W] = tbl_bytes[i*BYTE_W +: BYTE_W];
         end else if (item.op == OP_TBX) begin
            tbl_res[i*BYTE_W +: BYTE_W] = item.dest_old[i*BYTE_W +: BYTE_W];
         end
      end
   end

   always_comb begin
      result   = '0;
      fallback = 1'b0;
      case (item.op)
         OP_BSL: begin
            result = (item.first_src & item.dest_old) | (item.second_src & ~item.dest_old);
         end
         OP_BIT: begin
            result = (item.first_src & item.second_src) | (item.dest_old & ~item.second_src);
         end
         OP_BIF: begin
            result = (item.dest_old & item.second_src) | (item.first_src & ~item.second_src);
         end
         OP_TRN1, OP_TRN2, OP_ZIP1, OP_ZIP2, OP_UZP1, OP_UZP2: begin
            if (item.elem_size_log2 == ELEM_LOG2_FALLBACK) begin
               result   = item.first_src;
               fallback = 1'b1;
            end else begin
               result = perm_res;
            end
         end
         OP_EXT: begin
            if (item.ext_index[EXT_W-1]) begin
               result   = item.second_src;
               fallback = 1'b1;
            end else begin
               result = ext_res;
            end
         end
         OP_TBL, OP_TBX: begin
            result = tbl_res;
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

FILE: rtl/simd_select_permute_unit.sv
// top level of the simd select and permute unit
// usage:
//   req channel carries one instruction item per handshake (valid/ready);
//   rsp channel returns exactly one item per request, in order.
//   table load items write one 64-bit word of the lookup table and return
//   a zero result; tbl/tbx items read the table as left by earlier items.
// path: rsp_valid rises once an accepted item has passed the input register,
//   then the table read plus byte crossbar into the result register.
// throughput: one item per cycle while rsp_ready is high, set by the single-pass datapath; a load
//   followed directly by a lookup sees the new word.
// stall: when rsp_ready is low the result register holds, one more item
//   waits in the input register, and req_ready drops only when both are full.
// reset: synchronous, clears both valid flags and marks every table word
//   as unwritten, so the table reads as all zero; req_ready is low in reset.
module simd_select_permute_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [simd_sp_pkg::OP_W-1:0]         req_op,
   input  logic [simd_sp_pkg::ELEM_LOG2_W-1:0]  req_elem_size_log2,
   input  logic [simd_sp_pkg::VEC_W-1:0]        req_dest_old,
   input  logic [simd_sp_pkg::VEC_W-1:0]        req_first_src,
   input  logic [simd_sp_pkg::VEC_W-1:0]        req_second_src,
   input  logic [simd_sp_pkg::EXT_W-1:0]        req_ext_index,
   input  logic [simd_sp_pkg::REGS_W-1:0]       req_table_regs,
   input  logic [simd_sp_pkg::TBL_WORD_W-1:0]   req_table_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [simd_sp_pkg::VEC_W-1:0]        rsp_result,
   output logic                                 rsp_fallback
);
   import simd_sp_pkg::*;

   logic             req_acc;
   logic             s1_adv;
   logic             s1_valid_ff;
   logic             s1_valid_in;
   item_type         s1_item_ff;
   item_type         s1_item_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [VEC_W-1:0] rsp_result_ff;
   logic [VEC_W-1:0] rsp_result_in;
   logic             rsp_fallback_ff;
   logic             rsp_fallback_in;
   logic [VEC_W-1:0] tbl_bytes;
   logic             tbl_wr_en;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !reset && (!s1_valid_ff || s1_adv);
   assign req_acc   = req_valid && req_ready;
   assign tbl_wr_en = req_acc && (req_op == OP_LOAD);

   simd_sp_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (tbl_wr_en),
      .wr_addr  (req_table_word[WORD_AW-1:0]),
      .wr_data  (req_second_src),
      .rd_en    (req_acc),
      .rd_idx   (req_first_src),
      .rd_bytes (tbl_bytes)
   );

   simd_sp_alu u_alu (
      .item      (s1_item_ff),
      .tbl_bytes (tbl_bytes),
      .result    (rsp_result_in),
      .fallback  (rsp_fallback_in)
   );

   always_comb begin
      s1_item_in.op             = req_op;
      s1_item_in.elem_size_log2 = req_elem_size_log2;
      s1_item_in.dest_old       = req_dest_old;
      s1_item_in.first_src      = req_first_src;
      s1_item_in.second_src     = req_second_src;
      s1_item_in.ext_index      = req_ext_index;
      s1_item_in.table_regs     = req_table_regs;
      s1_valid_in  = req_acc || (s1_valid_ff && !s1_adv);
      rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_item_ff <= s1_item_in;
      end
      if (s1_adv) begin
         rsp_result_ff   <= rsp_result_in;
         rsp_fallback_ff <= rsp_fallback_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_result   = rsp_result_ff;
   assign rsp_fallback = rsp_fallback_ff;

`ifndef SYNTHESIS
   // a waiting item never disappears from the input register
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> s1_valid_ff)
      else $error("input stage item lost");

   // back pressure only when both stages are full and the output stalls
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("req_ready low without full pipeline");

   // table load items return zero
   a_load_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && (s1_item_ff.op == OP_LOAD)) |=> (rsp_result == '0 && !rsp_fallback))
      else $error("table load gave nonzero result");

   // fallback only from permutes and extract
   a_fallback_ops: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && rsp_fallback_in) |->
         (s1_item_ff.op == OP_TRN1 || s1_item_ff.op == OP_TRN2 ||
          s1_item_ff.op == OP_ZIP1 || s1_item_ff.op == OP_ZIP2 ||
          s1_item_ff.op == OP_UZP1 || s1_item_ff.op == OP_UZP2 ||
          s1_item_ff.op == OP_EXT))
      else $error("fallback flagged for non-permute op");
`endif

endmodule
